[sv/spcs_pkg.sv]
// Package for the strict-priority chunk sender: op and status codes, state type.
// No dependencies.
`default_nettype none
package spcs_pkg;
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SEND  = 3'd1,
        OP_TRUNC = 3'd2,
        OP_EMPTY = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_IDLE   = 2'd1,
        ST_FULL   = 2'd2,
        ST_FAILED = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } fsm_t;

    localparam logic [0:0] REG_ACTIVE_QUEUES = 1'd0;
    localparam logic [0:0] REG_CHUNK_SIZE    = 1'd1;
endpackage
`default_nettype wire

[sv/strict_priority_chunk_sender_top.sv]
// Strict-priority chunk sender: FIFO queues of message descriptors in one memory.
// Depends on spcs_pkg.
//
// Each request (start while not busy) reads the addressed descriptor from the
// descriptor memory into a register, then modifies and writes it back and
// presents the result. done strobes for one cycle with the result; the receiver
// cannot stall it. busy is high while the descriptor is written back. Descriptor data is used
// only from slots that have been written. Configuration writes are taken at any time.
`default_nettype none
module strict_priority_chunk_sender_top
    import spcs_pkg::*;
#(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  op,
    input  wire logic [7:0]  priority_req,
    input  wire logic [31:0] item_length,
    input  wire logic [31:0] item_id,
    input  wire logic        send_ok,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [1:0]       status,
    output logic [2:0]       served_queue,
    output logic [31:0]      item_id_out,
    output logic [31:0]      chunk_offset,
    output logic [15:0]      chunk_length,
    output logic             item_done
);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = QW + PW;
    localparam int NW = $clog2(NUM_QUEUES + 1);

    logic [95:0] mem [2**AW];
    logic [95:0] rd_reg;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [95:0] mem_wdata;

    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [PW-1:0] tail_reg [NUM_QUEUES];
    logic [CW-1:0] cnt_reg  [NUM_QUEUES];
    logic [31:0]   idc_reg;
    logic [3:0]    act_reg;
    logic [15:0]   cs_reg;

    fsm_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [QW-1:0] q_reg;
    logic        found_reg;
    logic [31:0] len_reg, id_reg;
    logic        ok_reg;

    logic [NW-1:0] n_act;
    logic [7:0]    n_m1;
    logic [QW-1:0] q_cl;
    logic [QW-1:0] sel_q;
    logic          sel_found;

    always_comb
    begin
        if (act_reg == 4'd0)
            n_act = NW'(1);
        else if (32'(act_reg) > NUM_QUEUES)
            n_act = NW'(NUM_QUEUES);
        else
            n_act = NW'(act_reg);
        n_m1 = 8'(n_act) - 8'd1;
        q_cl = (priority_req >= 8'(n_act)) ? QW'(n_m1) : QW'(priority_req);
        sel_q = '0;
        sel_found = 1'b0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (i < 32'(n_act) && cnt_reg[i] != '0)
            begin
                sel_q = QW'(i);
                sel_found = 1'b1;
            end
        end
    end

    wire accept = start && state_reg == S_IDLE;
    logic [QW-1:0] rq;
    assign rq = (op == OP_SEND) ? sel_q : q_cl;

    // read address: head slot of the requested queue; the write address is mem_addr
    logic [AW-1:0] rd_addr;
    assign rd_addr = {rq, head_reg[rq]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[rd_addr];
    end

    // decode of the descriptor being served
    logic [31:0] d_len, d_cur, d_id, rem, clen32, cur_new;
    logic [15:0] cs_eff;
    logic        pop;
    always_comb
    begin
        d_len = rd_reg[95:64];
        d_cur = rd_reg[63:32];
        d_id  = rd_reg[31:0];
        cs_eff = (cs_reg == 16'd0) ? 16'd1 : cs_reg;
        rem = (d_cur < d_len) ? d_len - d_cur : 32'd0;
        clen32 = (rem < 32'(cs_eff)) ? rem : 32'(cs_eff);
        cur_new = ok_reg ? d_cur + clen32 : d_cur;
        pop = cur_new >= d_len;
    end

    logic full;
    assign full = cnt_reg[q_reg] >= CW'(QUEUE_DEPTH);
    logic [31:0] new_id;
    assign new_id = (id_reg == 32'd0) ? idc_reg + 32'd1 : id_reg;

    always_comb
    begin
        state_next = state_reg;
        mem_we = 1'b0;
        mem_addr = {q_reg, tail_reg[q_reg]};
        mem_wdata = {len_reg, 32'd0, new_id};
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (op_reg == OP_ADD && !full)
                    mem_we = 1'b1;
                else if (op_reg == OP_SEND && found_reg)
                begin
                    mem_we = 1'b1;
                    mem_addr = {q_reg, head_reg[q_reg]};
                    mem_wdata = {d_len, cur_new, d_id};
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
    assign busy = state_reg == S_EXEC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg <= 4'd8;
            cs_reg <= 16'd64;
            idc_reg <= '0;
            done <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ACTIVE_QUEUES: act_reg <= cfg_data[3:0];
                    REG_CHUNK_SIZE:    cs_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_EXEC)
            begin
                done <= 1'b1;
                case (op_reg) inside
                    OP_ADD:
                        if (!full)
                        begin
                            if (id_reg == 32'd0)
                                idc_reg <= new_id;
                            tail_reg[q_reg] <= (32'(tail_reg[q_reg]) == QUEUE_DEPTH - 1)
                                ? '0 : tail_reg[q_reg] + PW'(1);
                            cnt_reg[q_reg] <= cnt_reg[q_reg] + CW'(1);
                        end
                    OP_SEND, OP_TRUNC:
                        if (found_reg && (op_reg == OP_TRUNC || pop))
                        begin
                            head_reg[q_reg] <= (32'(head_reg[q_reg]) == QUEUE_DEPTH - 1)
                                ? '0 : head_reg[q_reg] + PW'(1);
                            cnt_reg[q_reg] <= cnt_reg[q_reg] - CW'(1);
                        end
                    OP_EMPTY:
                    begin
                        head_reg[q_reg] <= '0;
                        tail_reg[q_reg] <= '0;
                        cnt_reg[q_reg] <= '0;
                    end
                    OP_CLEAR:
                        for (int i = 0; i < NUM_QUEUES; i++)
                            if (i < 32'(n_act))
                            begin
                                head_reg[i] <= '0;
                                tail_reg[i] <= '0;
                                cnt_reg[i] <= '0;
                            end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
            q_reg <= rq;
            found_reg <= (op == OP_SEND) ? sel_found : (cnt_reg[rq] != '0);
            len_reg <= item_length;
            id_reg <= item_id;
            ok_reg <= send_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            status <= ST_OK;
            served_queue <= '0;
            item_id_out <= '0;
            chunk_offset <= '0;
            chunk_length <= '0;
            item_done <= 1'b0;
            case (op_reg)
                OP_ADD:
                begin
                    served_queue <= 3'(q_reg);
                    if (full)
                        status <= ST_FULL;
                    else
                        item_id_out <= new_id;
                end
                OP_SEND:
                    if (!found_reg)
                        status <= ST_IDLE;
                    else
                    begin
                        status <= ok_reg ? ST_OK : ST_FAILED;
                        served_queue <= 3'(q_reg);
                        item_id_out <= d_id;
                        chunk_offset <= d_cur;
                        chunk_length <= clen32[15:0];
                        item_done <= pop;
                    end
                OP_TRUNC:
                begin
                    served_queue <= 3'(q_reg);
                    if (found_reg)
                    begin
                        item_id_out <= d_id;
                        item_done <= 1'b1;
                    end
                end
                OP_EMPTY:
                    served_queue <= 3'(q_reg);
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/spcs_checker.sv]
// Port-level checks for strict_priority_chunk_sender_top, bound to the top level.
// Depends on spcs_pkg.
`default_nettype none
module spcs_checker
    import spcs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [31:0] chunk_offset,
    input wire logic [15:0] chunk_length,
    input wire logic        item_done
);
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done) else $error("no result after request");
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result repeated");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_IDLE) |-> (chunk_length == 16'd0 && !item_done
        && chunk_offset == 32'd0)) else $error("idle result not empty");
endmodule

bind strict_priority_chunk_sender_top spcs_checker u_spcs_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .chunk_offset(chunk_offset), .chunk_length(chunk_length),
    .item_done(item_done)
);
`default_nettype wire

[verif/strict_priority_chunk_sender_top_tb.sv]
// Testbench for strict_priority_chunk_sender_top: directed and random requests, checked
// against an in-bench queue predictor. Depends on spcs_pkg and the top-level RTL.
`default_nettype none
module strict_priority_chunk_sender_top_tb
    import spcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = 8;
    localparam int QD = 16;

    typedef struct packed {
        status_t     status;
        logic [2:0]  served_queue;
        logic [31:0] item_id_out;
        logic [31:0] chunk_offset;
        logic [15:0] chunk_length;
        logic        item_done;
    } sched_result_t;

    class sched_scoreboard;
        logic [31:0]   len_mem [NQ][QD];
        logic [31:0]   cur_mem [NQ][QD];
        logic [31:0]   id_mem  [NQ][QD];
        int unsigned   head [NQ];
        int unsigned   tail [NQ];
        int unsigned   cnt  [NQ];
        logic [31:0]   id_ctr;
        logic [3:0]    act_reg;
        logic [15:0]   chunk_reg;
        sched_result_t pending_results[$];
        int            errors;

        function new();
            for (int q = 0; q < NQ; q++)
            begin
                head[q] = 0;
                tail[q] = 0;
                cnt[q]  = 0;
            end
            id_ctr    = '0;
            act_reg   = 4'd8;
            chunk_reg = 16'd64;
            errors    = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [15:0] val);
            if (idx == REG_ACTIVE_QUEUES)
                act_reg = val[3:0];
            else
                chunk_reg = val;
        endfunction

        function int unsigned live_queues();
            if (act_reg < 1)
                return 1;
            if (act_reg > NQ)
                return NQ;
            return act_reg;
        endfunction

        function void pop(int unsigned q);
            if (cnt[q] > 0)
            begin
                head[q] = (head[q] + 1) % QD;
                cnt[q]--;
            end
        endfunction

        function void note(op_t op, logic [7:0] prio, logic [31:0] len, logic [31:0] id,
                           logic ok);
            sched_result_t r;
            int unsigned   n;
            int unsigned   q;
            int            hit;
            logic [31:0]   cs;
            logic [31:0]   rem;
            logic [31:0]   clen;
            r = '{ST_OK, 3'd0, 32'd0, 32'd0, 16'd0, 1'b0};
            n = live_queues();
            q = (prio >= n) ? n - 1 : prio;
            hit = -1;
            case (op)
                OP_ADD:
                begin
                    r.served_queue = q[2:0];
                    if (cnt[q] >= QD)
                        r.status = ST_FULL;
                    else
                    begin
                        if (id == 0)
                        begin
                            id_ctr = id_ctr + 1;
                            id = id_ctr;
                        end
                        len_mem[q][tail[q]] = len;
                        cur_mem[q][tail[q]] = 0;
                        id_mem[q][tail[q]]  = id;
                        tail[q] = (tail[q] + 1) % QD;
                        cnt[q]++;
                        r.item_id_out = id;
                    end
                end
                OP_SEND:
                begin
                    for (int i = n - 1; i >= 0; i--)
                        if (cnt[i] > 0)
                            hit = i;
                    if (hit < 0)
                        r.status = ST_IDLE;
                    else
                    begin
                        q = hit;
                        cs = (chunk_reg == 0) ? 32'd1 : {16'd0, chunk_reg};
                        rem = (cur_mem[q][head[q]] < len_mem[q][head[q]]) ?
                              len_mem[q][head[q]] - cur_mem[q][head[q]] : 32'd0;
                        clen = (rem < cs) ? rem : cs;
                        r.chunk_length = clen[15:0];
                        r.served_queue = q[2:0];
                        r.item_id_out  = id_mem[q][head[q]];
                        r.chunk_offset = cur_mem[q][head[q]];
                        if (ok)
                            cur_mem[q][head[q]] = cur_mem[q][head[q]] + clen;
                        else
                            r.status = ST_FAILED;
                        if (cur_mem[q][head[q]] >= len_mem[q][head[q]])
                        begin
                            pop(q);
                            r.item_done = 1'b1;
                        end
                    end
                end
                OP_TRUNC:
                begin
                    r.served_queue = q[2:0];
                    if (cnt[q] > 0)
                    begin
                        r.item_id_out = id_mem[q][head[q]];
                        pop(q);
                        r.item_done = 1'b1;
                    end
                end
                OP_EMPTY:
                begin
                    r.served_queue = q[2:0];
                    head[q] = 0;
                    tail[q] = 0;
                    cnt[q]  = 0;
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        head[i] = 0;
                        tail[i] = 0;
                        cnt[i]  = 0;
                    end
                end
                default:
                    ;
            endcase
            pending_results.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR %0t: %s", $realtime, what);
            errors++;
        endtask

        task check(sched_result_t got);
            sched_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result strobe with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.served_queue !== want.served_queue)
                report($sformatf("served_queue %0d, want %0d", got.served_queue,
                                 want.served_queue));
            if (got.item_id_out !== want.item_id_out)
                report($sformatf("item_id_out %h, want %h", got.item_id_out,
                                 want.item_id_out));
            if (got.chunk_offset !== want.chunk_offset)
                report($sformatf("chunk_offset %h, want %h", got.chunk_offset,
                                 want.chunk_offset));
            if (got.chunk_length !== want.chunk_length)
                report($sformatf("chunk_length %h, want %h", got.chunk_length,
                                 want.chunk_length));
            if (got.item_done !== want.item_done)
                report($sformatf("item_done %b, want %b", got.item_done, want.item_done));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [7:0]  priority_req;
    logic [31:0] item_length;
    logic [31:0] item_id;
    logic        send_ok;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  served_queue;
    logic [31:0] item_id_out;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic        item_done;

    sched_scoreboard sb;
    int unsigned     cycles;
    int              idle_pct;

    strict_priority_chunk_sender_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .priority_req (priority_req),
        .item_length  (item_length),
        .item_id      (item_id),
        .send_ok      (send_ok),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .served_queue (served_queue),
        .item_id_out  (item_id_out),
        .chunk_offset (chunk_offset),
        .chunk_length (chunk_length),
        .item_done    (item_done)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check('{status_t'(status), served_queue, item_id_out, chunk_offset,
                       chunk_length, item_done});
    end

    // start stays high between back-to-back requests; lowered only for a gap
    task automatic issue(op_t o, logic [7:0] p, logic [31:0] l, logic [31:0] id,
                         logic ok);
        start        <= 1'b1;
        op           <= o;
        priority_req <= p;
        item_length  <= l;
        item_id      <= id;
        send_ok      <= ok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(o, p, l, id, ok);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_request();
        int unsigned sel;
        logic [7:0]  p;
        logic [31:0] l;
        logic [31:0] id;
        sel = $urandom_range(99);
        p   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(9));
        l   = ($urandom_range(19) == 0) ? $urandom : $urandom_range(300);
        id  = ($urandom_range(2) == 0) ? $urandom : 32'd0;
        if (sel < 36)
            issue(OP_ADD, p, l, id, 1'b0);
        else if (sel < 82)
            issue(OP_SEND, 8'($urandom), $urandom, $urandom, ($urandom_range(4) != 0));
        else if (sel < 91)
            issue(OP_TRUNC, p, $urandom, $urandom, 1'($urandom));
        else if (sel < 95)
            issue(OP_EMPTY, p, $urandom, $urandom, 1'($urandom));
        else if (sel < 97)
            issue(OP_CLEAR, p, $urandom, $urandom, 1'($urandom));
        else
            issue(op_t'($urandom_range(5, 7)), p, $urandom, $urandom, 1'($urandom));
    endtask

    initial
    begin
        logic [15:0] act_set [5];
        logic [15:0] chunk_set [5];
        act_set   = '{16'd1, 16'd0, 16'd15, 16'd3, 16'hFFF8};
        chunk_set = '{16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd100};
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ADD;
        priority_req = '0;
        item_length = '0;
        item_id = '0;
        send_ok = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ACTIVE_QUEUES;
        cfg_data = '0;
        cycles = 0;
        idle_pct = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, empty sends, extremes, full queue, odd ops
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_TRUNC, 8'd2, 32'd0, 32'd0, 1'b0);
        issue(OP_ADD, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        issue(OP_ADD, 8'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_ADD, 8'd0, 32'd130, 32'd0, 1'b0);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b1);
        issue(OP_SEND, 8'd0, 32'd0, 32'd0, 1'b0);
        issue(OP_TRUNC, 8'd7, 32'd0, 32'd0, 1'b0);
        for (int i = 0; i < QD + 1; i++)
            issue(OP_ADD, 8'd3, 32'(i), 32'd0, 1'b0);
        issue(op_t'(3'd5), 8'd1, 32'd5, 32'd5, 1'b1);
        issue(op_t'(3'd7), 8'd1, 32'd5, 32'd5, 1'b1);
        issue(OP_EMPTY, 8'd3, 32'd0, 32'd0, 1'b0);
        issue(OP_ADD, 8'd5, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0);
        issue(OP_CLEAR, 8'd0, 32'd0, 32'd0, 1'b0);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_ACTIVE_QUEUES, act_set[ph]);
            write_reg(REG_CHUNK_SIZE, chunk_set[ph]);
            idle_pct = (ph == 2) ? 0 : 37;
            for (int k = 0; k < 80; k++)
            begin
                random_request();
                if (k == 40)
                    drain();
            end
            drain();
        end
        write_reg(REG_ACTIVE_QUEUES, 16'd8);
        write_reg(REG_CHUNK_SIZE, 16'd64);
        idle_pct = 37;
        for (int k = 0; k < 60; k++)
            random_request();
        drain();
        repeat (10)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
